>>> rtl/rbm_pkg.sv
// shared types, codes and helpers for the bank mapper with real-time clock
package rbm_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    SRC_NONE   = 3'd0,
    SRC_DATA   = 3'd1,
    SRC_ROM    = 3'd2,
    SRC_RAM_RD = 3'd3,
    SRC_RAM_WR = 3'd4
  } src_t;

  typedef enum logic [1:0] {
    CFG_ROM_BANKS = 2'd0,
    CFG_RAM_BANKS = 2'd1,
    CFG_HAS_RTC   = 2'd2
  } cfg_idx_t;

  localparam logic [3:0] RTC_SEC    = 4'h8;
  localparam logic [3:0] RTC_MIN    = 4'h9;
  localparam logic [3:0] RTC_HOUR   = 4'hA;
  localparam logic [3:0] RTC_DAY_LO = 4'hB;
  localparam logic [3:0] RTC_DAY_HI = 4'hC;

  localparam logic [7:0] OPEN_BUS       = 8'hFF;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] LATCH_ARM      = 8'h00;
  localparam logic [7:0] LATCH_FIRE     = 8'h01;

  localparam logic [5:0] LAST_SEC  = 6'd59;
  localparam logic [5:0] LAST_MIN  = 6'd59;
  localparam logic [4:0] LAST_HOUR = 5'd23;

  typedef struct packed {
    logic       tick;
    logic       wr;
    logic       latch;
    logic [3:0] sel;
    logic [7:0] data;
  } rtc_ctl_t;

  typedef struct packed {
    logic [2:0]  source;
    logic [7:0]  read_data;
    logic [20:0] memory_address;
  } result_t;

  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    return r[5:0];
  endfunction

  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    return r[4:0];
  endfunction

endpackage

>>> rtl/rom_ram_bank_mapper_with_rtc_unit.sv
// top level: config registers, input and result registers around the mapper
//
//   port group  direction  handshake            payload
//   cfg         in         cfg_write            cfg_index, cfg_data
//   in          in         in_valid / in_stall  operation, address, write_data
//   out         out        out_valid / out_stall source, read_data, memory_address
//
// one item per cycle sustained while out_stall is low, set by the single decode stage
// between the input and result registers. synchronous reset clears control state, the
// ram bank select and the clock counters, and sets the rom bank select to 1.
// out_stall holds the result register; in_stall rises only when both registers are full.
module rom_ram_bank_mapper_with_rtc_unit #(
  parameter int ROM_BANK_BITS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  source,
  output logic [7:0]  read_data,
  output logic [20:0] memory_address
);

  logic [7:0] rom_banks;
  logic [2:0] ram_banks;
  logic       has_rtc;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;

  logic              out_free, fire;
  rbm_pkg::rtc_ctl_t ctl;
  rbm_pkg::result_t  res;
  logic [7:0]        rtc_value;

  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_banks <= 8'd128;
      ram_banks <= 3'd4;
      has_rtc   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        rbm_pkg::CFG_ROM_BANKS: rom_banks <= cfg_data;
        rbm_pkg::CFG_RAM_BANKS: ram_banks <= cfg_data[2:0];
        rbm_pkg::CFG_HAS_RTC:   has_rtc   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= operation;
      s1_addr <= address;
      s1_data <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      source         <= res.source;
      read_data      <= res.read_data;
      memory_address <= res.memory_address;
    end
  end

  rbm_mapper #(
    .ROM_BANK_BITS(ROM_BANK_BITS)
  ) u_mapper (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .op        (s1_op),
    .addr      (s1_addr),
    .data      (s1_data),
    .rom_banks (rom_banks),
    .ram_banks (ram_banks),
    .has_rtc   (has_rtc),
    .rtc_value (rtc_value),
    .ctl       (ctl),
    .res       (res)
  );

  rbm_rtc u_rtc (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .value (rtc_value)
  );

endmodule

>>> rtl/rbm_rtc.sv
// real-time clock: live counters, latch copy and register read mux
module rbm_rtc (
  input  logic              clk,
  input  logic              rst,
  input  rbm_pkg::rtc_ctl_t ctl,
  output logic [7:0]        value
);

  logic [5:0] seconds_count, minutes_count, held_seconds, held_minutes;
  logic [4:0] hours_count, held_hours;
  logic [8:0] days_count, held_days;
  logic       latch_armed, latch_taken;

  logic [5:0] s, m;
  logic [4:0] h;
  logic [8:0] d;

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= '0;
      minutes_count <= '0;
      hours_count   <= '0;
      days_count    <= '0;
      held_seconds  <= '0;
      held_minutes  <= '0;
      held_hours    <= '0;
      held_days     <= '0;
      latch_armed   <= 1'b0;
      latch_taken   <= 1'b0;
    end else begin
      if (ctl.tick) begin
        if (seconds_count != rbm_pkg::LAST_SEC) begin
          seconds_count <= seconds_count + 6'd1;
        end else begin
          seconds_count <= '0;
          if (minutes_count != rbm_pkg::LAST_MIN) begin
            minutes_count <= minutes_count + 6'd1;
          end else begin
            minutes_count <= '0;
            if (hours_count != rbm_pkg::LAST_HOUR) begin
              hours_count <= hours_count + 5'd1;
            end else begin
              hours_count <= '0;
              days_count  <= days_count + 9'd1;
            end
          end
        end
      end
      if (ctl.wr) begin
        case (ctl.sel)
          rbm_pkg::RTC_SEC:    seconds_count <= rbm_pkg::mod60(ctl.data);
          rbm_pkg::RTC_MIN:    minutes_count <= rbm_pkg::mod60(ctl.data);
          rbm_pkg::RTC_HOUR:   hours_count   <= rbm_pkg::mod24(ctl.data);
          rbm_pkg::RTC_DAY_LO: days_count    <= {days_count[8], ctl.data};
          rbm_pkg::RTC_DAY_HI: days_count    <= {ctl.data[0], days_count[7:0]};
          default: ;
        endcase
      end
      if (ctl.latch) begin
        if (ctl.data == rbm_pkg::LATCH_ARM) begin
          latch_armed <= 1'b1;
        end else if (ctl.data == rbm_pkg::LATCH_FIRE && latch_armed) begin
          held_seconds <= seconds_count;
          held_minutes <= minutes_count;
          held_hours   <= hours_count;
          held_days    <= days_count;
          latch_taken  <= 1'b1;
          latch_armed  <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    s = latch_taken ? held_seconds : seconds_count;
    m = latch_taken ? held_minutes : minutes_count;
    h = latch_taken ? held_hours   : hours_count;
    d = latch_taken ? held_days    : days_count;
    case (ctl.sel)
      rbm_pkg::RTC_SEC:    value = {2'b0, s};
      rbm_pkg::RTC_MIN:    value = {2'b0, m};
      rbm_pkg::RTC_HOUR:   value = {3'b0, h};
      rbm_pkg::RTC_DAY_LO: value = d[7:0];
      default:             value = {7'b0, d[8]};
    endcase
  end

endmodule

>>> rtl/rbm_mapper.sv
// bank registers and bus decode into a result and clock controls
module rbm_mapper #(
  parameter int ROM_BANK_BITS = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [1:0]        op,
  input  logic [15:0]       addr,
  input  logic [7:0]        data,
  input  logic [7:0]        rom_banks,
  input  logic [2:0]        ram_banks,
  input  logic              has_rtc,
  input  logic [7:0]        rtc_value,
  output rbm_pkg::rtc_ctl_t ctl,
  output rbm_pkg::result_t  res
);

  logic [ROM_BANK_BITS-1:0] rom_bank;
  logic [1:0]               ram_bank;
  logic [3:0]               selected_register;
  logic                     clock_selected;
  logic                     ram_enable;

  logic [ROM_BANK_BITS-1:0] rom_bank_wr;
  logic [6:0]               rom_bank_ext;
  logic                     in_ram_area, sel_is_ram, sel_is_rtc, data_is_rtc;

  assign rom_bank_ext = 7'(rom_bank);
  assign rom_bank_wr  = (data[ROM_BANK_BITS-1:0] == '0) ? ROM_BANK_BITS'(1)
                                                        : data[ROM_BANK_BITS-1:0];
  assign in_ram_area  = (addr[15:13] == 3'b101) && ram_enable;
  assign sel_is_ram   = (selected_register <= 4'd3) &&
                        (selected_register < {1'b0, ram_banks});
  assign sel_is_rtc   = (selected_register >= rbm_pkg::RTC_SEC) &&
                        (selected_register <= rbm_pkg::RTC_DAY_HI);
  assign data_is_rtc  = (data >= {4'b0, rbm_pkg::RTC_SEC}) &&
                        (data <= {4'b0, rbm_pkg::RTC_DAY_HI});

  always_comb begin
    res            = '0;
    ctl            = '0;
    ctl.sel        = selected_register;
    ctl.data       = data;
    res.source     = rbm_pkg::SRC_NONE;
    case (op)
      rbm_pkg::OP_READ: begin
        res.source    = rbm_pkg::SRC_DATA;
        res.read_data = rbm_pkg::OPEN_BUS;
        if (addr[15:14] == 2'b00) begin
          res.source         = rbm_pkg::SRC_ROM;
          res.read_data      = '0;
          res.memory_address = {5'b0, addr};
        end else if (addr[15:14] == 2'b01) begin
          if ({1'b0, rom_bank_ext} < rom_banks) begin
            res.source         = rbm_pkg::SRC_ROM;
            res.read_data      = '0;
            res.memory_address = {rom_bank_ext, addr[13:0]};
          end
        end else if (in_ram_area) begin
          if (sel_is_ram) begin
            res.source         = rbm_pkg::SRC_RAM_RD;
            res.read_data      = '0;
            res.memory_address = {6'b0, selected_register[1:0], addr[12:0]};
          end else if (sel_is_rtc && has_rtc) begin
            res.read_data = rtc_value;
          end
        end
      end
      rbm_pkg::OP_WRITE: begin
        ctl.latch = fire && (addr[15:13] == 3'b011);
        if (in_ram_area && !clock_selected) begin
          if ({1'b0, ram_bank} < ram_banks) begin
            res.source         = rbm_pkg::SRC_RAM_WR;
            res.memory_address = {6'b0, ram_bank, addr[12:0]};
          end
        end
        ctl.wr = fire && in_ram_area && clock_selected && has_rtc;
      end
      rbm_pkg::OP_TICK: ctl.tick = fire;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank          <= ROM_BANK_BITS'(1);
      ram_bank          <= '0;
      selected_register <= '0;
      clock_selected    <= 1'b0;
      ram_enable        <= 1'b0;
    end else if (fire && op == rbm_pkg::OP_WRITE) begin
      case (addr[15:13])
        3'b000: ram_enable <= (data[3:0] == rbm_pkg::RAM_ENABLE_KEY);
        3'b001: rom_bank   <= rom_bank_wr;
        3'b010: begin
          if (data <= 8'd3) begin
            ram_bank          <= data[1:0];
            selected_register <= data[3:0];
            clock_selected    <= 1'b0;
          end else if (data_is_rtc && has_rtc) begin
            selected_register <= data[3:0];
            clock_selected    <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
